### src/rrbac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrbac_pkg
// Shared constants for the round-robin bus arbiter: acknowledge codes,
// opcode threshold and slave page map.
// ----------------------------------------------------------------------------
package rrbac_pkg;

    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned OPC_W    = 4;
    localparam int unsigned ACK_W    = 3;
    localparam int unsigned SEL_W    = 5;
    localparam int unsigned PHASE_W  = 2;
    localparam int unsigned PAGE_W   = 20;
    localparam int unsigned PAGE_LSB = 10;

    localparam logic [ACK_W-1:0] ACK_READY      = 3'd2;
    localparam logic [ACK_W-1:0] ACK_READY_MORE = 3'd3;
    localparam logic [ACK_W-1:0] ACK_SPLIT      = 3'd4;

    // opcodes at or below this carry no transfer
    localparam logic [OPC_W-1:0] OPC_IDLE_MAX = 4'd1;

    localparam logic [PAGE_W-1:0] PAGE_S0 = 20'h00000;
    localparam logic [PAGE_W-1:0] PAGE_S1 = 20'h00400;
    localparam logic [PAGE_W-1:0] PAGE_S2 = 20'h80000;
    localparam logic [PAGE_W-1:0] PAGE_S3 = 20'hBFC00;
    localparam logic [PAGE_W-1:0] PAGE_S4 = 20'hC0000;

    localparam logic [SEL_W-1:0] SEL_S0   = 5'b00001;
    localparam logic [SEL_W-1:0] SEL_S1   = 5'b00010;
    localparam logic [SEL_W-1:0] SEL_S2   = 5'b00100;
    localparam logic [SEL_W-1:0] SEL_S3   = 5'b01000;
    localparam logic [SEL_W-1:0] SEL_S4   = 5'b10000;
    localparam logic [SEL_W-1:0] SEL_NONE = 5'b00000;

endpackage

`default_nettype wire

### src/rrbac_arbiter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrbac_arbiter
// Ring carry chain round-robin winner and parking (default) master select
// from the priority mask.
// ----------------------------------------------------------------------------
module rrbac_arbiter
    import rrbac_pkg::*;
#(
    parameter int unsigned NUM_MASTERS = 8
) (
    input  wire logic [NUM_MASTERS-1:0] i_request,
    input  wire logic [NUM_MASTERS-1:0] i_prio,
    output logic      [NUM_MASTERS-1:0] o_grant,
    output logic      [NUM_MASTERS-1:0] o_default
);

    localparam int unsigned IW = $clog2(NUM_MASTERS);

    logic [IW-1:0] start;
    logic [IW:0]   idx;
    logic          carry;
    logic          req_bit;

    // first zero of the mask starts the ring
    always_comb begin
        start = IW'(NUM_MASTERS - 1);
        for (int k = NUM_MASTERS - 1; k >= 0; k--) begin
            if (!i_prio[k]) begin
                start = IW'(k);
            end
        end
    end

    always_comb begin
        o_grant = '0;
        carry   = 1'b0;
        idx     = '0;
        req_bit = 1'b0;
        for (int k = 1; k <= NUM_MASTERS; k++) begin
            idx = {1'b0, start} + (IW + 1)'(k);
            if (idx >= (IW + 1)'(NUM_MASTERS)) begin
                idx = idx - (IW + 1)'(NUM_MASTERS);
            end
            req_bit = i_request[idx[IW-1:0]];
            if (req_bit && !carry) begin
                o_grant[idx[IW-1:0]] = 1'b1;
            end
            carry = i_prio[idx[IW-1:0]] & (carry | req_bit);
        end
    end

    // parked master sits just above the mask's zero
    always_comb begin
        for (int i = 0; i < NUM_MASTERS; i++) begin
            o_default[i] = i_prio[i] && !i_prio[(i + NUM_MASTERS - 1) % NUM_MASTERS];
        end
    end

endmodule

`default_nettype wire

### src/round_robin_bus_arbiter_controller_top.sv
`timescale 1ns / 1ps
`default_nettype none
// a word moves from the input register to the result register when that is
// empty or i_ready is high; throughput: one word per cycle with i_ready high,
// set by the single arbitration pass between the input and result registers
// reset: synchronous active low; mask returns to all ones but the top bit,
// bus phase to idle, no pending clear, both register stages empty
// ----------------------------------------------------------------------------
// round_robin_bus_arbiter_controller_top
// Round-robin bus arbiter with parking, four-phase bus sequencing and slave
// page decode, one bus phase per word.
// ----------------------------------------------------------------------------
module round_robin_bus_arbiter_controller_top
    import rrbac_pkg::*;
#(
    parameter int unsigned NUM_MASTERS = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [NUM_MASTERS-1:0] i_request,
    input  wire logic [ADDR_W-1:0]      i_address,
    input  wire logic                   i_lock,
    input  wire logic [OPC_W-1:0]       i_opcode,
    input  wire logic [ACK_W-1:0]       i_ack,
    input  wire logic                   i_clear_request,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic      [NUM_MASTERS-1:0] o_grant,
    output logic      [SEL_W-1:0]       o_slave_select,
    output logic      [PHASE_W-1:0]     o_bus_phase
);

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE = 2'd0,
        PH_FADR = 2'd1,
        PH_NADR = 2'd2,
        PH_LDAT = 2'd3
    } t_phase;

    localparam logic [NUM_MASTERS-1:0] MASK_RESET = {1'b0, {(NUM_MASTERS - 1){1'b1}}};

    logic                   r_s1_valid;
    logic [NUM_MASTERS-1:0] r_req;
    logic [ADDR_W-1:0]      r_addr;
    logic                   r_lock;
    logic [OPC_W-1:0]       r_opc;
    logic [ACK_W-1:0]       r_ack;
    logic                   r_clr;

    logic                   r_out_valid;
    logic [NUM_MASTERS-1:0] r_grant;
    logic [SEL_W-1:0]       r_sel;
    t_phase                 r_phase_out;

    logic [NUM_MASTERS-1:0] r_prio;
    t_phase                 r_phase;
    logic                   r_pend;

    logic [NUM_MASTERS-1:0] n_grant;
    logic [SEL_W-1:0]       n_sel;
    t_phase                 n_phase;
    logic [NUM_MASTERS-1:0] n_prio;

    logic [NUM_MASTERS-1:0] rr_grant;
    logic [NUM_MASTERS-1:0] dflt;
    logic [PAGE_W-1:0]      page;
    logic [SEL_W-1:0]       page_sel;
    logic                   any_req;
    logic                   xfer;
    logic                   data_rdy;
    logic                   dflt_req;
    logic                   advance;
    logic                   write_prio;

    assign advance = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || advance;

    rrbac_arbiter #(
        .NUM_MASTERS(NUM_MASTERS)
    ) u_arb (
        .i_request(r_req),
        .i_prio   (r_prio),
        .o_grant  (rr_grant),
        .o_default(dflt)
    );

    assign page = r_addr[PAGE_LSB +: PAGE_W];

    always_comb begin
        unique case (page)
            PAGE_S0: page_sel = SEL_S0;
            PAGE_S1: page_sel = SEL_S1;
            PAGE_S2: page_sel = SEL_S2;
            PAGE_S3: page_sel = SEL_S3;
            PAGE_S4: page_sel = SEL_S4;
            default: page_sel = SEL_NONE;
        endcase
    end

    assign any_req  = |r_req;
    assign xfer     = r_opc > OPC_IDLE_MAX;
    assign data_rdy = r_ack inside {ACK_READY, ACK_READY_MORE, ACK_SPLIT};
    assign dflt_req = |(dflt & r_req);

    always_comb begin
        n_grant    = '0;
        n_sel      = SEL_NONE;
        n_phase    = r_phase;
        write_prio = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                write_prio = any_req;
                if (!any_req) begin
                    n_grant = dflt;
                    n_phase = PH_IDLE;
                end else if (!dflt_req) begin
                    n_grant = rr_grant;
                    n_phase = PH_FADR;
                end else begin
                    n_sel   = page_sel;
                    n_phase = r_lock ? PH_FADR : PH_LDAT;
                end
            end
            PH_FADR: begin
                if (xfer) begin
                    n_sel = page_sel;
                end
                n_phase = r_lock ? PH_NADR : PH_LDAT;
            end
            PH_NADR: begin
                if (xfer && data_rdy) begin
                    n_sel = page_sel;
                end
                n_phase = r_lock ? PH_NADR : PH_LDAT;
            end
            PH_LDAT: begin
                write_prio = data_rdy && any_req;
                if (data_rdy) begin
                    n_grant = any_req ? rr_grant : dflt;
                    n_phase = any_req ? PH_FADR : PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        if (r_pend) begin
            n_phase = PH_IDLE;
        end
        n_prio = r_pend ? MASK_RESET : write_prio ? ~rr_grant : r_prio;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prio      <= MASK_RESET;
            r_phase     <= PH_IDLE;
            r_pend      <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (i_valid && o_ready) begin
                r_req  <= i_request;
                r_addr <= i_address;
                r_lock <= i_lock;
                r_opc  <= i_opcode;
                r_ack  <= i_ack;
                r_clr  <= i_clear_request;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_grant     <= n_grant;
                r_sel       <= n_sel;
                r_phase_out <= r_phase;
                r_prio      <= n_prio;
                r_phase     <= n_phase;
                r_pend      <= r_clr;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_grant        = r_grant;
    assign o_slave_select = r_sel;
    assign o_bus_phase    = r_phase_out;

`ifndef SYNTHESIS
    a_grant_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot0(o_grant))
        else $error("grant not one-hot");

    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot0(o_slave_select))
        else $error("slave select not one-hot");

    a_mask_one_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_prio) == NUM_MASTERS - 1)
        else $error("priority mask lost its single zero");

    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_pend) |=> (r_phase == PH_IDLE && r_prio == MASK_RESET))
        else $error("pending clear not applied");
`endif

endmodule

`default_nettype wire
